@@ hdl/lpd_pkg.sv @@
// Package for the streaming Levenshtein prefix distance block.
// Item types, configuration codes, sizing constants and the saturation helper.
// No dependencies.
package lpd_pkg;

    localparam int PATTERN_MAX     = 8;
    localparam int DIST_WIDTH      = 16;
    localparam int POS_WIDTH       = 16;
    localparam int TAP_WIDTH       = (PATTERN_MAX < 2) ? 1 : $clog2(PATTERN_MAX + 1);
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 64;

    localparam logic [DIST_WIDTH-1:0] ENTRY_MAX = {DIST_WIDTH{1'b1}};
    localparam logic [POS_WIDTH-1:0]  POS_MAX   = {POS_WIDTH{1'b1}};

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_PATTERN_CHARS  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic [15:0] distance;
        logic [15:0] prefix_length;
    } out_item_t;

    // One wavefront slot handed from a cell to its right neighbor.
    typedef struct packed {
        logic                  valid;
        logic [7:0]            symbol;
        logic                  first;
        logic [POS_WIDTH-1:0]  pos;
        logic [DIST_WIDTH-1:0] left;   // new entry of the sending cell
        logic [DIST_WIDTH-1:0] diag;   // entry of the sending cell before this byte
    } link_t;

    function automatic logic [DIST_WIDTH-1:0] sat_entry(input logic [31:0] v);
        logic [31:0] lim;
        lim = 32'(ENTRY_MAX);
        return (v > lim) ? ENTRY_MAX : v[DIST_WIDTH-1:0];
    endfunction

endpackage

@@ hdl/lpd_head.sv @@
// Head of the cell chain: text position counter, entry zero of the column.
// Depends on lpd_pkg.
module lpd_head
    import lpd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     take,
    input  in_item_t item,
    output link_t    link_out
);

    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [POS_WIDTH-1:0] pos_old;
    link_t                link_reg, link_next;

    always_comb begin
        pos_old  = item.first ? '0 : pos_reg;
        pos_next = (pos_old < POS_MAX) ? pos_old + 1'b1 : pos_old;

        link_next.valid  = take;
        link_next.symbol = item.symbol;
        link_next.first  = item.first;
        link_next.pos    = pos_next;
        link_next.left   = sat_entry(32'(pos_next));
        link_next.diag   = sat_entry(32'(pos_old));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            link_reg <= '0;
        end else if (en) begin
            link_reg <= link_next;
            if (take) begin
                pos_reg <= pos_next;
            end
        end
    end

    assign link_out = link_reg;

endmodule

@@ hdl/lpd_cell.sv @@
// One column cell: holds entry cell_index of the DP column for one pattern char.
// Depends on lpd_pkg.
module lpd_cell
    import lpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic [TAP_WIDTH-1:0] cell_index,
    input  logic [7:0]           pattern_char,
    input  link_t                link_in,
    output link_t                link_out
);

    logic [DIST_WIDTH-1:0] entry_reg, entry_next;
    logic [DIST_WIDTH-1:0] upper, best;
    link_t                 link_reg, link_next;

    always_comb begin
        // first byte of a text: own entry restarts at its index
        upper = link_in.first ? sat_entry(32'(cell_index)) : entry_reg;
        best  = (link_in.left < upper) ? link_in.left : upper;
        if (link_in.diag < best) begin
            best = link_in.diag;
        end
        if (pattern_char == link_in.symbol) begin
            entry_next = link_in.diag;
        end else if (best == ENTRY_MAX) begin
            entry_next = best;
        end else begin
            entry_next = best + 1'b1;
        end

        link_next.valid  = link_in.valid;
        link_next.symbol = link_in.symbol;
        link_next.first  = link_in.first;
        link_next.pos    = link_in.pos;
        link_next.left   = entry_next;
        link_next.diag   = upper;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= sat_entry(32'(cell_index));
            link_reg  <= '0;
        end else if (en) begin
            link_reg <= link_next;
            if (link_in.valid) begin
                entry_reg <= entry_next;
            end
        end
    end

    assign link_out = link_reg;

endmodule

@@ hdl/levenshtein_prefix_distance.sv @@
// Streaming Levenshtein distance of a short pattern to each text prefix.
// Top level: config registers, head, chain of lpd_cell, result tap.
// Depends on lpd_pkg, lpd_head, lpd_cell.
//
// Use:
//   - Config: write pattern_chars (index 0) and pattern_length (index 1) on
//     cfg_* while no items are in flight. cfg_ready is always high; other
//     indexes are dropped.
//   - Input: one text byte per item on s_*, with first set on the opening
//     byte of each text. Output: one item per byte on m_*, holding the
//     distance of the whole pattern to the prefix and the prefix length.
//   - Path: a byte passes the head register and then the register of each
//     cell in turn; its result is read from the stage of cell m (m = pattern
//     length, capped at PATTERN_MAX).
//   - Throughput: one item per cycle while not stalled; the chain is a
//     systolic wavefront, each cell taking a byte after its left neighbor.
//   - Stall: while m_valid is high and m_ready low the whole chain holds and
//     s_ready is low; nothing is lost or repeated.
//   - Reset: cell entries return to 1..PATTERN_MAX, text position to zero,
//     both config registers to zero, no items in flight.
module levenshtein_prefix_distance
    import lpd_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  in_item_t                   s_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output out_item_t                  m_item
);

    logic [8*PATTERN_MAX-1:0] pattern_chars_reg;
    logic [3:0]               pattern_length_reg;
    logic [3:0]               length_capped;
    logic [TAP_WIDTH-1:0]     tap;
    logic                     en;
    logic                     take;
    link_t                    stage [PATTERN_MAX+1];
    link_t                    tap_link;
    logic [31:0]              dist_wide;

    // ---- configuration ----
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_chars_reg  <= '0;
            pattern_length_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PATTERN_CHARS:  pattern_chars_reg  <= cfg_data[8*PATTERN_MAX-1:0];
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---- flow control: the chain moves as one ----
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign take    = s_valid && en;

    // ---- chain ----
    lpd_head u_head (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .take     (take),
        .item     (s_item),
        .link_out (stage[0])
    );

    for (genvar i = 1; i <= PATTERN_MAX; i++) begin : g_cell
        lpd_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .en           (en),
            .cell_index   (TAP_WIDTH'(i)),
            .pattern_char (pattern_chars_reg[8*(i-1) +: 8]),
            .link_in      (stage[i-1]),
            .link_out     (stage[i])
        );
    end

    // ---- result tap at the stage of the last pattern char in use ----
    assign length_capped = (pattern_length_reg > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX)
                                                                  : pattern_length_reg;
    assign tap       = length_capped[TAP_WIDTH-1:0];
    assign tap_link  = stage[tap];
    assign dist_wide = 32'(tap_link.left);

    assign m_valid              = tap_link.valid;
    assign m_item.distance      = (dist_wide > 32'h0000_FFFF) ? 16'hFFFF : dist_wide[15:0];
    assign m_item.prefix_length = tap_link.pos;

    // ---- checks ----
    a_first_pos : assert property (@(posedge aclk) disable iff (!aresetn)
        take && s_item.first |=> stage[0].valid && stage[0].pos == 16'd1)
        else $error("head did not restart text position on first byte");

    a_pos_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.prefix_length != 16'd0)
        else $error("result with zero prefix length");

    a_dist_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.distance <= m_item.prefix_length ||
                     m_item.distance <= 16'(length_capped)))
        else $error("distance exceeds longer of pattern and prefix");

    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(tap_link.left))
        else $error("chain moved while result was stalled");

endmodule
